>>> hdl/sensor_window_alert_monitor_defines.svh
// ----------------------------------------------------------------------------
// Sensor window alert monitor: assertion macros
// Shared property macros; defining NO_ASSERTIONS turns them into nothing.
// ----------------------------------------------------------------------------
`ifndef SENSOR_WINDOW_ALERT_MONITOR_DEFINES_SVH
`define SENSOR_WINDOW_ALERT_MONITOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication: whenever ante holds, cons holds too.
`define SWAM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sensor window alert monitor: implication violated");
// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define SWAM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sensor window alert monitor: sequence violated");
`else
`define SWAM_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define SWAM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> hdl/swam_pkg.sv
// ----------------------------------------------------------------------------
// Sensor window alert monitor package
// Field widths, result codes, register indexes and shared types.
// ----------------------------------------------------------------------------
package swam_pkg;

   localparam int OUT_W      = 16;
   localparam int LIMIT_W    = 16;
   localparam int METRIC_W   = 8;
   localparam int STATUS_W   = 2;
   localparam int LEVEL_W    = 2;
   localparam int INTERVAL_W = 32;
   localparam int READS_W    = 16;
   localparam int COUNT_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Window status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BELOW = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ABOVE = 2'd2;

   // Monitoring levels.
   localparam logic [LEVEL_W-1:0] LEVEL_OK      = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_WARNING = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_ALERT   = 2'd2;

   // Escalation counter value on entry to WARNING from OK.
   localparam logic [COUNT_W-1:0] COUNT_ON_WARN = 8'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_LOWER_LIMIT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_UPPER_LIMIT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OK_BOUND       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ALERT_BOUND    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_START_INTERVAL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_START_READS    = 3'd5;

   // Reset values of the configuration registers.
   localparam logic signed [LIMIT_W-1:0] RST_LOWER_LIMIT    = -16'sd32768;
   localparam logic signed [LIMIT_W-1:0] RST_UPPER_LIMIT    = 16'sd32767;
   localparam logic [COUNT_W-1:0]        RST_OK_BOUND       = 8'd0;
   localparam logic [COUNT_W-1:0]        RST_ALERT_BOUND    = 8'd4;
   localparam logic [INTERVAL_W-1:0]     RST_START_INTERVAL = 32'd60000;
   localparam logic [READS_W-1:0]        RST_START_READS    = 16'd16;

   // Window sequencer states.
   typedef enum logic [2:0] {
      ST_COLLECT = 3'b001,
      ST_DIVIDE  = 3'b010,
      ST_FINISH  = 3'b100
   } seq_state_type;

   // Status reported by the divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

>>> hdl/swam_div.sv
// ----------------------------------------------------------------------------
// Sensor window alert monitor: iterative divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "sensor_window_alert_monitor_defines.svh"

module swam_div #(
   parameter int DVD_W = 25,
   parameter int DVS_W = 9
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DVD_W-1:0]         dividend,
   input  logic [DVS_W-1:0]         divisor,
   output logic [DVD_W-1:0]         quotient,
   output swam_pkg::div_status_type stat
);

   localparam int CW = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   partial;
   logic [DVS_W+1:0] diff;
   logic             borrow;

   // The quotient register first holds the dividend; each step shifts one
   // dividend bit into the remainder and one quotient bit in at the bottom.
   assign partial = {rem_ff, quo_ff[DVD_W-1]};
   assign diff    = {1'b0, partial} - {2'b00, dvs_ff};
   assign borrow  = diff[DVS_W+1];

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], ~borrow};
         rem_in = borrow ? partial[DVS_W-1:0] : diff[DVS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   `SWAM_ASSERT_IMPLY(a_div_start_idle, clock, reset, start, !busy_ff)
   `SWAM_ASSERT_IMPLY(a_div_count_live, clock, reset, busy_ff, cnt_ff != '0)
   `SWAM_ASSERT_NEXT(a_div_done_pulse, clock, reset, done_ff, !done_ff)

endmodule

>>> hdl/sensor_window_alert_monitor.sv
// ----------------------------------------------------------------------------
// Sensor window alert monitor
// Window min / max / mean statistics with an adaptive OK-WARNING-ALERT level.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Word
//   req      in         req_valid/req_stall   sample, window end flag, metric id
//   rsp      out        rsp_valid/rsp_stall   min, max, mean, metric id, status, level, rates, count
//   csr      in         csr_valid/csr_ready   register index and write data
//
// A sample that does not close a window is taken without a stall, so such
// words stream at one per cycle. After a closing word, req_stall stays high
// while the block launches the divider, runs the restoring division at one
// quotient bit per cycle, sees it finish and loads the result register. If
// the previous result is still stalled at that point, the block waits
// until it is taken.
// Reset is synchronous and active high; it restores the register defaults
// and loads the push interval and reads per window from their start values.
//
`include "sensor_window_alert_monitor_defines.svh"

module sensor_window_alert_monitor #(
   parameter int MAX_WINDOW  = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample,
   input  logic                                   req_window_end,
   input  logic [swam_pkg::METRIC_W-1:0]          req_metric_id,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [swam_pkg::OUT_W-1:0]      rsp_min_out,
   output logic signed [swam_pkg::OUT_W-1:0]      rsp_max_out,
   output logic signed [swam_pkg::OUT_W-1:0]      rsp_mean_out,
   output logic [swam_pkg::METRIC_W-1:0]          rsp_metric_out,
   output logic [swam_pkg::STATUS_W-1:0]          rsp_window_status,
   output logic [swam_pkg::LEVEL_W-1:0]           rsp_level_out,
   output logic [swam_pkg::INTERVAL_W-1:0]        rsp_interval_out,
   output logic [swam_pkg::READS_W-1:0]           rsp_reads_out,
   output logic [swam_pkg::COUNT_W-1:0]           rsp_count_out,

   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [swam_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [swam_pkg::CSR_DATA_W-1:0]        csr_data
);

   // Count must be able to hold MAX_WINDOW itself; the sum holds MAX_WINDOW
   // samples of full range without overflow.
   localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W  = SAMPLE_BITS + CNT_W;
   localparam int CMP_W  = (SAMPLE_BITS > swam_pkg::LIMIT_W) ? SAMPLE_BITS : swam_pkg::LIMIT_W;
   localparam int OUT_W  = swam_pkg::OUT_W;
   localparam int LIM_W  = swam_pkg::LIMIT_W;
   localparam int INT_W  = swam_pkg::INTERVAL_W;
   localparam int RD_W   = swam_pkg::READS_W;
   localparam int CT_W   = swam_pkg::COUNT_W;

   // ------------------------------------------------------------------------
   // Declarations
   // ------------------------------------------------------------------------
   swam_pkg::seq_state_type state_ff, state_in;

   logic signed [LIM_W-1:0]       lower_ff, lower_in;
   logic signed [LIM_W-1:0]       upper_ff, upper_in;
   logic [CT_W-1:0]               ok_bound_ff, ok_bound_in;
   logic [CT_W-1:0]               alert_bound_ff, alert_bound_in;
   logic [INT_W-1:0]              start_intv_ff, start_intv_in;
   logic [RD_W-1:0]               start_reads_ff, start_reads_in;

   logic signed [SAMPLE_BITS-1:0] run_min_ff, run_min_in;
   logic signed [SAMPLE_BITS-1:0] run_max_ff, run_max_in;
   logic signed [SUM_W-1:0]       run_sum_ff, run_sum_in;
   logic [CNT_W-1:0]              run_count_ff, run_count_in;
   logic [swam_pkg::METRIC_W-1:0] metric_ff, metric_in;

   logic [swam_pkg::LEVEL_W-1:0]  level_ff, level_in;
   logic [CT_W-1:0]               esc_ff, esc_in;
   logic [INT_W-1:0]              intv_ff, intv_in;
   logic [RD_W-1:0]               reads_ff, reads_in;

   logic                          div_go_ff, div_go_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]       out_min_ff, out_max_ff, out_mean_ff;
   logic [swam_pkg::METRIC_W-1:0] out_metric_ff;
   logic [swam_pkg::STATUS_W-1:0] out_status_ff;
   logic [swam_pkg::LEVEL_W-1:0]  out_level_ff;
   logic [INT_W-1:0]              out_intv_ff;
   logic [RD_W-1:0]               out_reads_ff;
   logic [CT_W-1:0]               out_esc_ff;

   logic                          req_accept;
   logic                          csr_write;
   logic                          out_free;
   logic                          finish;
   logic                          room;
   logic signed [SUM_W-1:0]       sample_ext;

   logic                          sum_neg;
   logic [SUM_W-1:0]              sum_mag;
   logic [SUM_W-1:0]              quotient;
   logic signed [SUM_W-1:0]       mean_full;
   swam_pkg::div_status_type      div_stat;

   logic signed [CMP_W-1:0]       min_ext, max_ext, lower_ext, upper_ext;
   logic [swam_pkg::STATUS_W-1:0] status;
   logic                          window_bad;

   logic [CT_W-1:0]               esc_dec, esc_inc;
   logic [INT_W-1:0]              intv_half, intv_dbl, intv_half_raw;
   logic [RD_W-1:0]               reads_half, reads_dbl, reads_half_raw;
   logic [swam_pkg::LEVEL_W-1:0]  step_level;
   logic [CT_W-1:0]               step_esc;
   logic [INT_W-1:0]              step_intv;
   logic [RD_W-1:0]               step_reads;

   // ------------------------------------------------------------------------
   // Handshakes. Samples are taken only while collecting; configuration is
   // accepted then too, so it never races with a level update.
   // ------------------------------------------------------------------------
   assign req_stall  = (state_ff != swam_pkg::ST_COLLECT);
   assign csr_ready  = (state_ff == swam_pkg::ST_COLLECT);
   assign req_accept = req_valid && !req_stall;
   assign csr_write  = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign finish     = (state_ff == swam_pkg::ST_FINISH) && out_free;

   // ------------------------------------------------------------------------
   // Window sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      div_go_in = 1'b0;
      case (state_ff)
         swam_pkg::ST_COLLECT: begin
            if (req_accept && req_window_end) begin
               state_in  = swam_pkg::ST_DIVIDE;
               div_go_in = 1'b1;
            end
         end
         swam_pkg::ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = swam_pkg::ST_FINISH;
            end
         end
         swam_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = swam_pkg::ST_COLLECT;
            end
         end
         default: begin
            state_in = swam_pkg::ST_COLLECT;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Running statistics. Once the window holds MAX_WINDOW samples further
   // samples are dropped, though a closing word still closes the window.
   // ------------------------------------------------------------------------
   assign room       = run_count_ff < CNT_W'(MAX_WINDOW);
   assign sample_ext = SUM_W'(req_sample);

   always_comb begin
      run_min_in   = run_min_ff;
      run_max_in   = run_max_ff;
      run_sum_in   = run_sum_ff;
      run_count_in = run_count_ff;
      metric_in    = metric_ff;
      if (req_accept && room) begin
         if (run_count_ff == '0) begin
            run_min_in = req_sample;
            run_max_in = req_sample;
         end else begin
            if (req_sample < run_min_ff) begin
               run_min_in = req_sample;
            end
            if (req_sample > run_max_ff) begin
               run_max_in = req_sample;
            end
         end
         run_sum_in   = run_sum_ff + sample_ext;
         run_count_in = run_count_ff + 1'b1;
      end
      if (req_accept && req_window_end) begin
         metric_in = req_metric_id;
      end
      if (finish) begin
         run_sum_in   = '0;
         run_count_in = '0;
      end
   end

   // ------------------------------------------------------------------------
   // Mean: the magnitude of the sum goes through the divider and the sign is
   // put back afterwards, which truncates toward zero. The count is never
   // zero here: the closing sample is counted unless the window is already full.
   // ------------------------------------------------------------------------
   assign sum_neg = run_sum_ff[SUM_W-1];
   assign sum_mag = sum_neg ? (~run_sum_ff + 1'b1) : run_sum_ff;

   swam_div #(
      .DVD_W (SUM_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (sum_mag),
      .divisor  (run_count_ff),
      .quotient (quotient),
      .stat     (div_stat)
   );

   assign mean_full = sum_neg ? -$signed(quotient) : $signed(quotient);

   // ------------------------------------------------------------------------
   // Window verdict: a minimum below the lower limit wins over a maximum
   // above the upper limit.
   // ------------------------------------------------------------------------
   assign min_ext   = CMP_W'(run_min_ff);
   assign max_ext   = CMP_W'(run_max_ff);
   assign lower_ext = CMP_W'(lower_ff);
   assign upper_ext = CMP_W'(upper_ff);

   always_comb begin
      if (min_ext < lower_ext) begin
         status = swam_pkg::STATUS_BELOW;
      end else if (max_ext > upper_ext) begin
         status = swam_pkg::STATUS_ABOVE;
      end else begin
         status = swam_pkg::STATUS_OK;
      end
   end

   assign window_bad = (status != swam_pkg::STATUS_OK);

   // ------------------------------------------------------------------------
   // Level machine. Escalating halves the push interval and reads per window
   // (never below one); de-escalating doubles them, saturating at full scale.
   // ------------------------------------------------------------------------
   assign esc_dec = (esc_ff == '0) ? esc_ff : esc_ff - 1'b1;
   assign esc_inc = (esc_ff == '1) ? esc_ff : esc_ff + 1'b1;

   assign intv_half_raw  = intv_ff >> 1;
   assign intv_half      = (intv_half_raw == '0) ? INT_W'(1) : intv_half_raw;
   assign intv_dbl       = intv_ff[INT_W-1] ? '1 : {intv_ff[INT_W-2:0], 1'b0};
   assign reads_half_raw = reads_ff >> 1;
   assign reads_half     = (reads_half_raw == '0) ? RD_W'(1) : reads_half_raw;
   assign reads_dbl      = reads_ff[RD_W-1] ? '1 : {reads_ff[RD_W-2:0], 1'b0};

   always_comb begin
      step_level = level_ff;
      step_esc   = esc_ff;
      step_intv  = intv_ff;
      step_reads = reads_ff;
      case (level_ff)
         swam_pkg::LEVEL_WARNING: begin
            if (!window_bad) begin
               step_esc = esc_dec;
               if (esc_dec <= ok_bound_ff) begin
                  step_level = swam_pkg::LEVEL_OK;
                  step_intv  = intv_dbl;
                  step_reads = reads_dbl;
               end
            end else begin
               step_esc = esc_inc;
               if (esc_inc >= alert_bound_ff) begin
                  step_level = swam_pkg::LEVEL_ALERT;
                  step_intv  = intv_half;
                  step_reads = reads_half;
               end
            end
         end
         swam_pkg::LEVEL_ALERT: begin
            if (!window_bad) begin
               step_esc = esc_dec;
               if (esc_dec < alert_bound_ff) begin
                  step_level = swam_pkg::LEVEL_WARNING;
                  step_intv  = intv_dbl;
                  step_reads = reads_dbl;
               end
            end else begin
               step_esc = esc_inc;
            end
         end
         default: begin
            // OK, and the unused code, which behaves as OK.
            if (window_bad) begin
               step_level = swam_pkg::LEVEL_WARNING;
               step_esc   = swam_pkg::COUNT_ON_WARN;
               step_intv  = intv_half;
               step_reads = reads_half;
            end
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Configuration registers and level state. Writing a start value also
   // reloads the live value, with zero taken as one.
   // ------------------------------------------------------------------------
   always_comb begin
      lower_in       = lower_ff;
      upper_in       = upper_ff;
      ok_bound_in    = ok_bound_ff;
      alert_bound_in = alert_bound_ff;
      start_intv_in  = start_intv_ff;
      start_reads_in = start_reads_ff;
      level_in       = level_ff;
      esc_in         = esc_ff;
      intv_in        = intv_ff;
      reads_in       = reads_ff;
      if (csr_write) begin
         case (csr_index)
            swam_pkg::REG_LOWER_LIMIT: begin
               lower_in = csr_data[LIM_W-1:0];
            end
            swam_pkg::REG_UPPER_LIMIT: begin
               upper_in = csr_data[LIM_W-1:0];
            end
            swam_pkg::REG_OK_BOUND: begin
               ok_bound_in = csr_data[CT_W-1:0];
            end
            swam_pkg::REG_ALERT_BOUND: begin
               alert_bound_in = csr_data[CT_W-1:0];
            end
            swam_pkg::REG_START_INTERVAL: begin
               start_intv_in = csr_data[INT_W-1:0];
               intv_in       = (csr_data[INT_W-1:0] == '0) ? INT_W'(1) : csr_data[INT_W-1:0];
            end
            swam_pkg::REG_START_READS: begin
               start_reads_in = csr_data[RD_W-1:0];
               reads_in       = (csr_data[RD_W-1:0] == '0) ? RD_W'(1) : csr_data[RD_W-1:0];
            end
            default: begin
            end
         endcase
      end else if (finish) begin
         level_in = step_level;
         esc_in   = step_esc;
         intv_in  = step_intv;
         reads_in = step_reads;
      end
   end

   // Result register: loaded when the window finishes, freed when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= swam_pkg::ST_COLLECT;
         div_go_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         lower_ff       <= swam_pkg::RST_LOWER_LIMIT;
         upper_ff       <= swam_pkg::RST_UPPER_LIMIT;
         ok_bound_ff    <= swam_pkg::RST_OK_BOUND;
         alert_bound_ff <= swam_pkg::RST_ALERT_BOUND;
         start_intv_ff  <= swam_pkg::RST_START_INTERVAL;
         start_reads_ff <= swam_pkg::RST_START_READS;
         run_sum_ff     <= '0;
         run_count_ff   <= '0;
         level_ff       <= swam_pkg::LEVEL_OK;
         esc_ff         <= '0;
         intv_ff        <= swam_pkg::RST_START_INTERVAL;
         reads_ff       <= swam_pkg::RST_START_READS;
      end else begin
         state_ff       <= state_in;
         div_go_ff      <= div_go_in;
         rsp_valid_ff   <= rsp_valid_in;
         lower_ff       <= lower_in;
         upper_ff       <= upper_in;
         ok_bound_ff    <= ok_bound_in;
         alert_bound_ff <= alert_bound_in;
         start_intv_ff  <= start_intv_in;
         start_reads_ff <= start_reads_in;
         run_sum_ff     <= run_sum_in;
         run_count_ff   <= run_count_in;
         level_ff       <= level_in;
         esc_ff         <= esc_in;
         intv_ff        <= intv_in;
         reads_ff       <= reads_in;
      end
      run_min_ff <= run_min_in;
      run_max_ff <= run_max_in;
      metric_ff  <= metric_in;
      if (finish) begin
         out_min_ff    <= OUT_W'(run_min_ff);
         out_max_ff    <= OUT_W'(run_max_ff);
         out_mean_ff   <= OUT_W'(mean_full);
         out_metric_ff <= metric_ff;
         out_status_ff <= status;
         out_level_ff  <= step_level;
         out_intv_ff   <= step_intv;
         out_reads_ff  <= step_reads;
         out_esc_ff    <= step_esc;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_min_out       = out_min_ff;
   assign rsp_max_out       = out_max_ff;
   assign rsp_mean_out      = out_mean_ff;
   assign rsp_metric_out    = out_metric_ff;
   assign rsp_window_status = out_status_ff;
   assign rsp_level_out     = out_level_ff;
   assign rsp_interval_out  = out_intv_ff;
   assign rsp_reads_out     = out_reads_ff;
   assign rsp_count_out     = out_esc_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `SWAM_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, run_count_ff <= CNT_W'(MAX_WINDOW))
   `SWAM_ASSERT_IMPLY(a_divisor_nonzero, clock, reset, state_ff != swam_pkg::ST_COLLECT, run_count_ff != '0)
   `SWAM_ASSERT_IMPLY(a_done_in_divide, clock, reset, div_stat.done, state_ff == swam_pkg::ST_DIVIDE)
   `SWAM_ASSERT_IMPLY(a_rates_nonzero, clock, reset, 1'b1, intv_ff != '0 && reads_ff != '0)
   `SWAM_ASSERT_NEXT(a_result_loaded, clock, reset, finish, rsp_valid_ff && state_ff == swam_pkg::ST_COLLECT)

endmodule
